// ===== hw/rtl/frequency_ranked_table_assert.svh =====
// ----------------------------------------------------------------------------
// frequency_ranked_table_assert.svh
// Assertion macros used by the checker file of the ranked table.
// ----------------------------------------------------------------------------
`ifndef FREQUENCY_RANKED_TABLE_ASSERT_SVH
`define FREQUENCY_RANKED_TABLE_ASSERT_SVH

// Clocked assertion, switched off while reset is high.
`define FRT_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Clocked assertion that also holds through reset.
`define FRT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/frt_pkg.sv =====
// ----------------------------------------------------------------------------
// frt_pkg
// Types, sizes and command codes of the frequency ranked table.
// ----------------------------------------------------------------------------
package frt_pkg;

  localparam int DEPTH      = 16;
  localparam int KEY_BITS   = 64;
  localparam int COUNT_BITS = 16;

  localparam int IDX_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_BITS = IDX_BITS + 1;
  localparam int CMP_BITS = (CNT_BITS > 4) ? CNT_BITS : 4;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [CNT_BITS-1:0]   USED_FULL = CNT_BITS'(DEPTH);
  localparam logic [4:0]            OCC_FULL  = 5'(DEPTH);

  localparam logic KIND_TOUCH = 1'b0;
  localparam logic KIND_READ  = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [63:0] entry_key;
    logic [63:0] payload;
    logic [3:0]  rank;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic        dropped;
    logic [3:0]  position;
    logic [15:0] use_count;
    logic [63:0] found_key;
    logic [63:0] found_payload;
    logic [4:0]  occupancy;
  } rsp_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [63:0]           payload;
    logic [COUNT_BITS-1:0] count;
  } entry_t;

  localparam int ENTRY_BITS = $bits(entry_t);

  // One datapath micro-operation per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_READ_RANK,
    OP_SCAN_START,
    OP_SCAN_NEXT,
    OP_HOLD,
    OP_SHIFT_PREP,
    OP_SHIFT_MOVE,
    OP_PLACE,
    OP_INSERT,
    OP_RES_READ,
    OP_RES_EMPTY,
    OP_RES_ENTRY,
    OP_RES_DROP
  } dp_op_t;

  typedef struct packed {
    logic   load;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic read_ok;
    logic match;
    logic sat;
    logic last;
    logic hole_zero;
    logic hole_one;
    logic move;
  } dp_stat_t;

endpackage

// ===== hw/rtl/frt_req_if.sv =====
// ----------------------------------------------------------------------------
// frt_req_if
// Request channel: touch or read items with valid/ready.
// ----------------------------------------------------------------------------
interface frt_req_if import frt_pkg::*; ();
  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/frt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// frt_rsp_if
// Response channel: one result per request, valid/ready.
// ----------------------------------------------------------------------------
interface frt_rsp_if import frt_pkg::*; ();
  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== hw/rtl/frequency_ranked_table.sv =====
// ----------------------------------------------------------------------------
// frequency_ranked_table
// Use-count ordered table of key/payload entries with touch and read requests.
// ----------------------------------------------------------------------------
//   channel | dir | payload                                      | handshake
//   --------+-----+----------------------------------------------+----------
//   req     | in  | kind, entry_key, payload, rank               | valid/ready
//   rsp     | out | hit, dropped, position, use_count,           | valid/ready
//           |     | found_key, found_payload, occupancy          |
//
// One request at a time. A read fetches the entry at its rank and registers
// the result; an empty rank is answered without a RAM read. A touch scans
// the entry RAM one entry per cycle through its single read port, from rank
// 0 up to the key or the last used entry; a raised count then moves the
// entry ahead of every entry with a smaller count. Results sit in an output
// register; a new request is taken while one waits. Reset empties the table.
// ----------------------------------------------------------------------------
module frequency_ranked_table import frt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  frt_req_if.sink    req,
  frt_rsp_if.source  rsp
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  frt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_kind  (req.data.kind),
    .req_ready (req.ready),
    .rsp_ready (rsp.ready),
    .rsp_valid (rsp.valid),
    .stat      (stat),
    .cmd       (cmd)
  );

  frt_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .req_data (req.data),
    .cmd      (cmd),
    .stat     (stat),
    .rsp_data (rsp.data)
  );

endmodule

// ===== hw/rtl/frt_ram.sv =====
// ----------------------------------------------------------------------------
// frt_ram
// Generic RAM, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module frt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                            clk,
  input  logic                            wr_en,
  input  logic [$clog2(DEPTH)-1:0]        wr_addr,
  input  logic [WIDTH-1:0]                wr_data,
  input  logic                            rd_en,
  input  logic [$clog2(DEPTH)-1:0]        rd_addr,
  output logic [WIDTH-1:0]                rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hw/rtl/frt_dp.sv =====
// ----------------------------------------------------------------------------
// frt_dp
// Datapath: entry RAM, scan/hole index, held entry, fill count, result reg.
// ----------------------------------------------------------------------------
module frt_dp import frt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  req_t     req_data,
  input  dp_cmd_t  cmd,
  output dp_stat_t stat,
  output rsp_t     rsp_data
);

  logic [KEY_BITS-1:0] key_reg;
  logic [63:0]         pay_reg;
  logic [3:0]          rank_reg;
  logic [CNT_BITS-1:0] used;
  logic [IDX_BITS-1:0] idx;
  logic [IDX_BITS-1:0] didx;
  entry_t              hold;
  rsp_t                res;

  logic                  wr_en;
  logic [IDX_BITS-1:0]   wr_addr;
  entry_t                wr_entry;
  logic                  rd_en;
  logic [IDX_BITS-1:0]   rd_addr;
  logic [ENTRY_BITS-1:0] rd_data;
  entry_t                rd_entry;
  entry_t                new_entry;

  assign rd_entry  = entry_t'(rd_data);
  assign new_entry = '{key: key_reg, payload: pay_reg, count: COUNT_BITS'(1)};

  frt_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // RAM port steering
  always_comb begin
    rd_en    = 1'b0;
    rd_addr  = idx;
    wr_en    = 1'b0;
    wr_addr  = idx;
    wr_entry = hold;
    unique case (cmd.op)
      OP_READ_RANK: begin
        rd_en   = 1'b1;
        rd_addr = IDX_BITS'(rank_reg);
      end
      OP_SCAN_START: begin
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      OP_SCAN_NEXT: begin
        rd_en = 1'b1;
      end
      OP_SHIFT_PREP: begin
        rd_en   = 1'b1;
        rd_addr = idx - IDX_BITS'(1);
      end
      OP_SHIFT_MOVE: begin
        // entry above the hole drops into it; fetch the next one up
        rd_en    = 1'b1;
        rd_addr  = idx - IDX_BITS'(2);
        wr_en    = 1'b1;
        wr_entry = rd_entry;
      end
      OP_PLACE: begin
        wr_en = 1'b1;
      end
      OP_INSERT: begin
        wr_en    = 1'b1;
        wr_addr  = IDX_BITS'(used);
        wr_entry = new_entry;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.op == OP_INSERT) begin
      used <= used + CNT_BITS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_reg  <= KEY_BITS'(req_data.entry_key);
      pay_reg  <= req_data.payload;
      rank_reg <= req_data.rank;
    end
    unique case (cmd.op)
      OP_SCAN_START: begin
        idx  <= IDX_BITS'(1);
        didx <= '0;
      end
      OP_SCAN_NEXT: begin
        idx  <= idx + IDX_BITS'(1);
        didx <= idx;
      end
      OP_HOLD: begin
        hold <= '{key: key_reg, payload: rd_entry.payload,
                  count: rd_entry.count + COUNT_BITS'(1)};
        idx  <= didx;
      end
      OP_SHIFT_MOVE: begin
        idx <= idx - IDX_BITS'(1);
      end
      OP_PLACE: begin
        res <= '{hit: 1'b1, dropped: 1'b0, position: 4'(idx),
                 use_count: 16'(hold.count), found_key: 64'(hold.key),
                 found_payload: hold.payload, occupancy: 5'(used)};
      end
      OP_INSERT: begin
        res <= '{hit: 1'b0, dropped: 1'b0, position: 4'(used),
                 use_count: 16'd1, found_key: 64'(key_reg),
                 found_payload: pay_reg, occupancy: 5'(used + CNT_BITS'(1))};
      end
      OP_RES_READ: begin
        res <= '{hit: 1'b1, dropped: 1'b0, position: rank_reg,
                 use_count: 16'(rd_entry.count), found_key: 64'(rd_entry.key),
                 found_payload: rd_entry.payload, occupancy: 5'(used)};
      end
      OP_RES_EMPTY: begin
        res <= '{hit: 1'b0, dropped: 1'b0, position: rank_reg,
                 use_count: '0, found_key: '0, found_payload: '0,
                 occupancy: 5'(used)};
      end
      OP_RES_ENTRY: begin
        // count already saturated: entry stays where it is
        res <= '{hit: 1'b1, dropped: 1'b0, position: 4'(didx),
                 use_count: 16'(rd_entry.count), found_key: 64'(rd_entry.key),
                 found_payload: rd_entry.payload, occupancy: 5'(used)};
      end
      OP_RES_DROP: begin
        res <= '{hit: 1'b0, dropped: 1'b1, position: '0,
                 use_count: '0, found_key: '0, found_payload: '0,
                 occupancy: 5'(used)};
      end
      default: begin
      end
    endcase
  end

  assign stat.empty     = (used == '0);
  assign stat.full      = (used == USED_FULL);
  assign stat.read_ok   = (CMP_BITS'(rank_reg) < CMP_BITS'(used));
  assign stat.match     = (rd_entry.key == key_reg);
  assign stat.sat       = (rd_entry.count == COUNT_MAX);
  assign stat.last      = ((CNT_BITS'(didx) + CNT_BITS'(1)) == used);
  assign stat.hole_zero = (idx == '0);
  assign stat.hole_one  = (idx == IDX_BITS'(1));
  assign stat.move      = (rd_entry.count < hold.count);

  assign rsp_data = res;

endmodule

// ===== hw/rtl/frt_ctrl.sv =====
// ----------------------------------------------------------------------------
// frt_ctrl
// Controller: sequences scan, promotion shift, insert and read per request.
// ----------------------------------------------------------------------------
module frt_ctrl import frt_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     req_kind,
  output logic     req_ready,
  input  logic     rsp_ready,
  output logic     rsp_valid,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_IDLE       = 6'b000001,
    ST_DISPATCH   = 6'b000010,
    ST_SCAN       = 6'b000100,
    ST_SHIFT_PREP = 6'b001000,
    ST_SHIFT      = 6'b010000,
    ST_READ       = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;
  logic   kind;
  logic   out_busy;
  logic   res_op;
  logic   rsp_valid_next;

  assign req_ready = (state == ST_IDLE);
  assign out_busy  = rsp_valid && !rsp_ready;

  always_comb begin
    state_next = state;
    cmd.load   = 1'b0;
    cmd.op     = OP_NONE;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        // start only once the output register is free
        if (!out_busy) begin
          if (kind == KIND_READ) begin
            if (stat.read_ok) begin
              cmd.op     = OP_READ_RANK;
              state_next = ST_READ;
            end else begin
              cmd.op     = OP_RES_EMPTY;
              state_next = ST_IDLE;
            end
          end else if (stat.empty) begin
            cmd.op     = OP_INSERT;
            state_next = ST_IDLE;
          end else begin
            cmd.op     = OP_SCAN_START;
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (stat.match) begin
          if (stat.sat) begin
            cmd.op     = OP_RES_ENTRY;
            state_next = ST_IDLE;
          end else begin
            cmd.op     = OP_HOLD;
            state_next = ST_SHIFT_PREP;
          end
        end else if (stat.last) begin
          cmd.op     = stat.full ? OP_RES_DROP : OP_INSERT;
          state_next = ST_IDLE;
        end else begin
          cmd.op = OP_SCAN_NEXT;
        end
      end
      ST_SHIFT_PREP: begin
        if (stat.hole_zero) begin
          cmd.op     = OP_PLACE;
          state_next = ST_IDLE;
        end else begin
          cmd.op     = OP_SHIFT_PREP;
          state_next = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (stat.move) begin
          cmd.op     = OP_SHIFT_MOVE;
          state_next = stat.hole_one ? ST_SHIFT_PREP : ST_SHIFT;
        end else begin
          cmd.op     = OP_PLACE;
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd.op     = OP_RES_READ;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign res_op = (cmd.op == OP_PLACE)     || (cmd.op == OP_INSERT)    ||
                  (cmd.op == OP_RES_READ)  || (cmd.op == OP_RES_EMPTY) ||
                  (cmd.op == OP_RES_ENTRY) || (cmd.op == OP_RES_DROP);

  always_comb begin
    priority if (res_op) begin
      rsp_valid_next = 1'b1;
    end else if (rsp_ready) begin
      rsp_valid_next = 1'b0;
    end else begin
      rsp_valid_next = rsp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state     <= state_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind <= req_kind;
    end
  end

endmodule

// ===== hw/rtl/frt_checker.sv =====
// ----------------------------------------------------------------------------
// frt_checker
// Port-level checks of the ranked table, bound to the top level.
// ----------------------------------------------------------------------------
`include "frequency_ranked_table_assert.svh"

module frt_checker import frt_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic rsp_valid,
  input logic rsp_ready,
  input rsp_t rsp_data
);

  `FRT_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "result changed while stalled")

  `FRT_ASSERT(a_drop_shape, clk, rst, rsp_valid && rsp_data.dropped |-> !rsp_data.hit && rsp_data.occupancy == OCC_FULL && rsp_data.use_count == '0, "bad dropped result")

  `FRT_ASSERT_ALWAYS(a_rst_empty, clk, rst |=> !rsp_valid, "result valid after reset")

  `FRT_ASSERT(a_one_at_a_time, clk, rst, req_valid && req_ready |=> !req_ready, "request taken while busy")

endmodule

bind frequency_ranked_table frt_checker u_frt_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);

// ===== bench/frequency_ranked_table_tb.sv =====
// ----------------------------------------------------------------------------
// frequency_ranked_table_tb
// Drives touch and read requests into the ranked table and checks every
// response against a cycle-free model of the count-ordered table kept here.
// Covers empty reads, inserts, promotion with stable ties, ignored payload
// on hits, full-table drops, and random idling on both channels including
// one long response stall that backs up the request side.
// ----------------------------------------------------------------------------
module frequency_ranked_table_tb;
  import frt_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int  N_RANDOM    = 850;
  localparam int  N_CALM      = 40;
  localparam int  CYCLE_LIMIT = 200000;
  localparam int  POOL_SIZE   = 24;

  logic clk;
  logic rst;

  frt_req_if req_ch ();
  frt_rsp_if rsp_ch ();

  frequency_ranked_table u_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #6 clk = ~clk;

  // Shadow of the table contents, ordered by rank.
  logic [63:0]           tbl_key [DEPTH];
  logic [63:0]           tbl_pay [DEPTH];
  logic [COUNT_BITS-1:0] tbl_cnt [DEPTH];
  int                    tbl_used;

  req_t queued_requests[$];
  rsp_t predicted_results[$];

  int error_count;
  int transfers_in;
  int calm_from;
  int idle_pct;
  int gap_left;
  int stall_left;
  int hold_left;
  bit hold_done;
  int cycle_count;

  // Apply one request to the shadow table and return the response it gives.
  function automatic rsp_t apply_request(req_t r);
    rsp_t                  res;
    logic [63:0]           k;
    logic [63:0]           p;
    logic [COUNT_BITS-1:0] c;
    int                    i;
    res = '0;
    k   = 64'(r.entry_key[KEY_BITS-1:0]);
    if (r.kind == KIND_READ) begin
      res.position = r.rank;
      if (int'(r.rank) < tbl_used) begin
        res.hit           = 1'b1;
        res.use_count     = 16'(tbl_cnt[r.rank]);
        res.found_key     = tbl_key[r.rank];
        res.found_payload = tbl_pay[r.rank];
      end
      res.occupancy = 5'(tbl_used);
      return res;
    end
    i = 0;
    while (i < tbl_used && tbl_key[i] != k) i++;
    if (i < tbl_used) begin
      if (tbl_cnt[i] != COUNT_MAX) begin
        c = tbl_cnt[i] + 1'b1;
        p = tbl_pay[i];
        // move ahead of strictly smaller counts only, ties keep order
        while (i > 0 && tbl_cnt[i-1] < c) begin
          tbl_key[i] = tbl_key[i-1];
          tbl_pay[i] = tbl_pay[i-1];
          tbl_cnt[i] = tbl_cnt[i-1];
          i--;
        end
        tbl_key[i] = k;
        tbl_pay[i] = p;
        tbl_cnt[i] = c;
      end
      res.hit           = 1'b1;
      res.position      = 4'(i);
      res.use_count     = 16'(tbl_cnt[i]);
      res.found_key     = tbl_key[i];
      res.found_payload = tbl_pay[i];
    end else if (tbl_used >= DEPTH) begin
      res.dropped = 1'b1;
    end else begin
      tbl_key[i]        = k;
      tbl_pay[i]        = r.payload;
      tbl_cnt[i]        = COUNT_BITS'(1);
      tbl_used          = tbl_used + 1;
      res.position      = 4'(i);
      res.use_count     = 16'd1;
      res.found_key     = k;
      res.found_payload = r.payload;
    end
    res.occupancy = 5'(tbl_used);
    return res;
  endfunction

  function automatic req_t touch_req(logic [63:0] k, logic [63:0] p);
    req_t r;
    r           = '0;
    r.kind      = KIND_TOUCH;
    r.entry_key = k;
    r.payload   = p;
    r.rank      = 4'($urandom_range(15));
    return r;
  endfunction

  function automatic req_t read_req(logic [3:0] rk);
    req_t r;
    r           = '0;
    r.kind      = KIND_READ;
    r.entry_key = {$urandom, $urandom};
    r.payload   = {$urandom, $urandom};
    r.rank      = rk;
    return r;
  endfunction

  task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s mismatch: expected %h, got %h", name, exp_val, act_val);
      error_count++;
    end
  endtask

  // Request driver
  always @(posedge clk) begin
    bit sent;
    if (rst) begin
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      gap_left     <= 0;
      transfers_in <= 0;
      idle_pct     <= 20;
    end else begin
      sent = req_ch.valid && req_ch.ready;
      if (sent) begin
        predicted_results.push_back(apply_request(req_ch.data));
        void'(queued_requests.pop_front());
        transfers_in <= transfers_in + 1;
        if (transfers_in % 50 == 49) begin
          case ($urandom_range(2))
            0: idle_pct <= 0;
            1: idle_pct <= 15;
            default: idle_pct <= 45;
          endcase
        end
      end
      if (req_ch.valid && !sent) begin
        // hold the offer until it transfers
      end else if (gap_left != 0) begin
        gap_left     <= gap_left - 1;
        req_ch.valid <= 1'b0;
      end else if (queued_requests.size() == 0) begin
        req_ch.valid <= 1'b0;
      end else if (transfers_in >= calm_from || $urandom_range(99) >= idle_pct) begin
        req_ch.valid <= 1'b1;
        req_ch.data  <= queued_requests[0];
      end else begin
        gap_left     <= $urandom_range(4);
        req_ch.valid <= 1'b0;
      end
    end
  end

  // One long response stall so the table backs up its request side
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && transfers_in >= 150) begin
      hold_left <= 400;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Response monitor
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (predicted_results.size() == 0) begin
          $error("response transfer with no request outstanding");
          error_count++;
        end else begin
          exp_rsp = predicted_results.pop_front();
          check_field("hit", 64'(exp_rsp.hit), 64'(rsp_ch.data.hit));
          check_field("dropped", 64'(exp_rsp.dropped), 64'(rsp_ch.data.dropped));
          check_field("position", 64'(exp_rsp.position), 64'(rsp_ch.data.position));
          check_field("use_count", 64'(exp_rsp.use_count), 64'(rsp_ch.data.use_count));
          check_field("found_key", exp_rsp.found_key, rsp_ch.data.found_key);
          check_field("found_payload", exp_rsp.found_payload, rsp_ch.data.found_payload);
          check_field("occupancy", 64'(exp_rsp.occupancy), 64'(rsp_ch.data.occupancy));
        end
      end
      if (hold_left != 0) begin
        rsp_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left   <= stall_left - 1;
        rsp_ch.ready <= 1'b0;
      end else if (transfers_in < calm_from && $urandom_range(99) < idle_pct) begin
        stall_left   <= $urandom_range(4);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [63:0] key_pool [POOL_SIZE];
    logic [63:0] all_ones;
    int          pick;
    clk          = 1'b0;
    rst          = 1'b1;
    all_ones     = '1;

    // empty table, first inserts, promotion, tie, payload ignored on a hit
    queued_requests.push_back(read_req(4'd0));
    queued_requests.push_back(read_req(4'd15));
    queued_requests.push_back(touch_req(64'd0, all_ones));
    queued_requests.push_back(touch_req(all_ones, 64'd0));
    queued_requests.push_back(touch_req(all_ones, 64'h1234_5678_9abc_def0));
    queued_requests.push_back(touch_req(64'd0, 64'h0f0f_0f0f_0f0f_0f0f));
    queued_requests.push_back(read_req(4'd0));
    queued_requests.push_back(read_req(4'd1));
    queued_requests.push_back(read_req(4'd2));
    queued_requests.push_back(touch_req(64'd0, 64'd0));

    // random traffic over a small key set so hits, promotion and drops occur
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    repeat (N_RANDOM) begin
      pick = $urandom_range(99);
      if (pick < 65)
        queued_requests.push_back(touch_req(key_pool[$urandom_range($urandom_range(POOL_SIZE-1))],
                                            {$urandom, $urandom}));
      else if (pick < 90)
        queued_requests.push_back(read_req(4'($urandom_range(15))));
      else
        queued_requests.push_back(touch_req({$urandom, $urandom}, {$urandom, $urandom}));
    end

    // back-to-back tail: hammer one key, then read both ends of the table
    calm_from = queued_requests.size();
    repeat (N_CALM)
      queued_requests.push_back(touch_req(all_ones, {$urandom, $urandom}));
    queued_requests.push_back(read_req(4'd0));
    queued_requests.push_back(read_req(4'd15));
    queued_requests.push_back(touch_req(64'd0, 64'd0));
    queued_requests.push_back(touch_req({$urandom, $urandom}, {$urandom, $urandom}));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (queued_requests.size() != 0 || predicted_results.size() != 0 || req_ch.valid)
      @(posedge clk);
    repeat (60) @(posedge clk);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/frt_pkg.sv
hw/rtl/frt_req_if.sv
hw/rtl/frt_rsp_if.sv
hw/rtl/frt_ram.sv
hw/rtl/frt_dp.sv
hw/rtl/frt_ctrl.sv
hw/rtl/frequency_ranked_table.sv
hw/rtl/frt_checker.sv
bench/frequency_ranked_table_tb.sv
